// File: design/m2gcv_pkg.sv
package m2gcv_pkg;

   localparam int GATE_COUNT    = 8;
   localparam int PITCH_ENTRIES = 61;
   localparam int GIDX_W        = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;
   localparam int PIDX_W        = (PITCH_ENTRIES > 1) ? $clog2(PITCH_ENTRIES) : 1;
   localparam int QUEUE_DEPTH   = 2;
   localparam int BASE_ENTRIES  = 61;

   localparam logic [7:0]  STATUS_LOW    = 8'h80;
   localparam logic [7:0]  STATUS_HIGH   = 8'hEF;
   localparam logic [7:0]  STATUS_FILTER = 8'hEF;
   localparam logic [3:0]  NOTE_ON_NIB   = 4'h9;
   localparam logic [15:0] PITCH_TOP     = 16'hFFF0;

   localparam logic REQ_MIDI = 1'b0;
   localparam logic REQ_MAP  = 1'b1;

   localparam logic [2:0] FIELD_KIND      = 3'd0;
   localparam logic [2:0] FIELD_GATE_STAT = 3'd1;
   localparam logic [2:0] FIELD_GATE_NOTE = 3'd2;
   localparam logic [2:0] FIELD_CV_STAT   = 3'd3;
   localparam logic [2:0] FIELD_CV_NUM    = 3'd4;

   localparam logic [1:0] KIND_VEL   = 2'd0;
   localparam logic [1:0] KIND_CC    = 2'd1;
   localparam logic [1:0] KIND_PITCH = 2'd2;

   localparam logic [7:0] GATE_STAT_RESET = 8'h80;
   localparam int         GATE_NOTE_BASE  = 24;

   localparam logic [15:0] SEMITONE_BASE [BASE_ENTRIES] = '{
      16'h0000, 16'h0440, 16'h0880, 16'h0CD0, 16'h1110, 16'h1550, 16'h19A0, 16'h1DE0,
      16'h2220, 16'h2660, 16'h2AA0, 16'h2EF0, 16'h3330, 16'h3770, 16'h3BC0, 16'h4000,
      16'h4440, 16'h4880, 16'h4CC0, 16'h5110, 16'h5550, 16'h5990, 16'h5DE0, 16'h6220,
      16'h6660, 16'h6AA0, 16'h6EE0, 16'h7330, 16'h7770, 16'h7BB0, 16'h8000, 16'h8440,
      16'h8880, 16'h8CC0, 16'h9100, 16'h9550, 16'h9990, 16'h9DD0, 16'hA220, 16'hA660,
      16'hAAA0, 16'hAEE0, 16'hB320, 16'hB770, 16'hBBB0, 16'hBFF0, 16'hC440, 16'hC880,
      16'hCCC0, 16'hD100, 16'hD550, 16'hD990, 16'hDDD0, 16'hE210, 16'hE660, 16'hEAA0,
      16'hEEE0, 16'hF320, 16'hF760, 16'hFBB0, 16'hFFF0
   };

   typedef struct packed {
      logic       is_map;
      logic [2:0] gate;
      logic [2:0] field;
      logic [7:0] value;
      logic [7:0] status;
      logic [7:0] data1;
      logic [7:0] data2;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  gate_index;
      logic        gate_write;
      logic        gate_level;
      logic        dac_write;
      logic [11:0] dac_code;
   } res_type;

   function automatic logic [15:0] pitch_code(input logic [PIDX_W-1:0] idx);
      logic [15:0] r;
      r = PITCH_TOP;
      for (int i = 0; i < BASE_ENTRIES; i++) begin
         if (int'(idx) == i) begin
            r = SEMITONE_BASE[i];
         end
      end
      return r;
   endfunction

endpackage

// File: design/m2gcv_front.sv
module m2gcv_front
   import m2gcv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic       in_type,
   input  logic [7:0] in_byte,
   input  logic [2:0] in_gate,
   input  logic [2:0] in_field,
   input  logic [7:0] in_value,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);

   typedef enum logic [1:0] {
      PH_STATUS = 2'd0,
      PH_DATA1  = 2'd1,
      PH_DATA2  = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] status_ff, status_in;
   logic [7:0] data1_ff, data1_in;
   logic       take;

   assign in_ready = !q_full;
   assign take     = in_valid && !q_full;

   always_comb begin
      phase_in  = phase_ff;
      status_in = status_ff;
      data1_in  = data1_ff;
      q_push    = 1'b0;
      q_cmd     = '0;
      q_cmd.gate   = in_gate;
      q_cmd.field  = in_field;
      q_cmd.value  = in_value;
      q_cmd.status = status_ff;
      q_cmd.data1  = data1_ff;
      q_cmd.data2  = in_byte;
      if (take) begin
         if (in_type == REQ_MAP) begin
            q_cmd.is_map = 1'b1;
            q_push = (int'(in_gate) < GATE_COUNT) && (in_field <= FIELD_CV_NUM);
         end else begin
            unique case (phase_ff)
               PH_DATA1: begin
                  data1_in = in_byte;
                  phase_in = PH_DATA2;
               end
               PH_DATA2: begin
                  phase_in = PH_STATUS;
                  q_push   = 1'b1;
               end
               default: begin
                  phase_in = PH_STATUS;
                  if (in_byte >= STATUS_LOW && in_byte <= STATUS_HIGH) begin
                     status_in = in_byte;
                     phase_in  = PH_DATA1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_STATUS;
         status_ff <= '0;
         data1_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         data1_ff  <= data1_in;
      end
   end

endmodule

// File: design/m2gcv_queue.sv
module m2gcv_queue
   import m2gcv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    not_empty,
   input  logic    pop,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_cmd   = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// File: design/m2gcv_back.sv
module m2gcv_back
   import m2gcv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    out_valid,
   input  logic    out_ready,
   output res_type out_res,
   output logic    out_last
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_FLUSH = 2'd2
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        kind_ff [GATE_COUNT];
   logic [1:0]        kind_in [GATE_COUNT];
   logic [7:0]        gstat_ff [GATE_COUNT];
   logic [7:0]        gstat_in [GATE_COUNT];
   logic [7:0]        gnote_ff [GATE_COUNT];
   logic [7:0]        gnote_in [GATE_COUNT];
   logic [7:0]        cstat_ff [GATE_COUNT];
   logic [7:0]        cstat_in [GATE_COUNT];
   logic [7:0]        cnum_ff [GATE_COUNT];
   logic [7:0]        cnum_in [GATE_COUNT];
   logic [7:0]        status_ff, status_in;
   logic [7:0]        data1_ff, data1_in;
   logic [7:0]        data2_ff, data2_in;
   logic [PIDX_W-1:0] pidx_ff, pidx_in;
   logic [GIDX_W-1:0] idx_ff, idx_in;
   logic              pend_valid_ff, pend_valid_in;
   res_type           pend_ff, pend_in;
   logic              out_valid_ff, out_valid_in;
   res_type           out_res_ff, out_res_in;
   logic              out_last_ff, out_last_in;
   logic              out_free;
   logic              noteon;
   logic [11:0]       cc_code;
   logic [15:0]       pitch_value;
   logic              hit;
   res_type           res;
   logic [GIDX_W-1:0] wgate;

   assign out_valid   = out_valid_ff;
   assign out_res     = out_res_ff;
   assign out_last    = out_last_ff;
   assign out_free    = !out_valid_ff || out_ready;
   assign noteon      = (status_ff[7:4] == NOTE_ON_NIB);
   assign cc_code     = {data2_ff[6:0], 5'b0};
   assign pitch_value = pitch_code(pidx_ff);
   assign wgate       = GIDX_W'(cmd.gate);

   // match of the entry under the scan pointer
   always_comb begin
      hit = 1'b0;
      res = '0;
      res.gate_index = 3'(idx_ff);
      if ((status_ff & STATUS_FILTER) == gstat_ff[idx_ff]) begin
         if (data1_ff == gnote_ff[idx_ff] || kind_ff[idx_ff] == KIND_PITCH) begin
            hit            = 1'b1;
            res.gate_write = 1'b1;
            res.gate_level = noteon;
            case (kind_ff[idx_ff])
               KIND_VEL: begin
                  res.dac_write = 1'b1;
                  res.dac_code  = noteon ? cc_code : '0;
               end
               KIND_PITCH: begin
                  res.dac_write = 1'b1;
                  res.dac_code  = pitch_value[15:4];
               end
               default: ;
            endcase
         end
      end else if (status_ff == cstat_ff[idx_ff] && data1_ff == cnum_ff[idx_ff]) begin
         hit           = 1'b1;
         res.dac_write = 1'b1;
         res.dac_code  = cc_code;
      end
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      gstat_in      = gstat_ff;
      gnote_in      = gnote_ff;
      cstat_in      = cstat_ff;
      cnum_in       = cnum_ff;
      status_in     = status_ff;
      data1_in      = data1_ff;
      data2_in      = data2_ff;
      pidx_in       = pidx_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      out_res_in    = out_res_ff;
      out_last_in   = out_last_ff;
      cmd_pop       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.is_map) begin
                  case (cmd.field)
                     FIELD_KIND:      kind_in[wgate]  = cmd.value[1:0];
                     FIELD_GATE_STAT: gstat_in[wgate] = cmd.value;
                     FIELD_GATE_NOTE: gnote_in[wgate] = cmd.value;
                     FIELD_CV_STAT:   cstat_in[wgate] = cmd.value;
                     FIELD_CV_NUM:    cnum_in[wgate]  = cmd.value;
                     default: ;
                  endcase
               end else begin
                  status_in     = cmd.status;
                  data1_in      = cmd.data1;
                  data2_in      = cmd.data2;
                  pidx_in       = (int'(cmd.data1) < PITCH_ENTRIES) ?
                                  PIDX_W'(cmd.data1) : PIDX_W'(PITCH_ENTRIES - 1);
                  idx_in        = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_res_in   = pend_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_in       = res;
                  pend_valid_in = 1'b1;
               end
               if (idx_ff == GIDX_W'(GATE_COUNT - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_res_in   = pend_ff;
                  out_last_in  = 1'b1;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         status_ff     <= '0;
         data1_ff      <= '0;
         for (int g = 0; g < GATE_COUNT; g++) begin
            kind_ff[g]  <= KIND_VEL;
            gstat_ff[g] <= GATE_STAT_RESET;
            gnote_ff[g] <= 8'(GATE_NOTE_BASE + g);
            cstat_ff[g] <= '0;
            cnum_ff[g]  <= '0;
         end
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         status_ff     <= status_in;
         data1_ff      <= data1_in;
         kind_ff       <= kind_in;
         gstat_ff      <= gstat_in;
         gnote_ff      <= gnote_in;
         cstat_ff      <= cstat_in;
         cnum_ff       <= cnum_in;
      end
      data2_ff    <= data2_in;
      pidx_ff     <= pidx_in;
      idx_ff      <= idx_in;
      pend_ff     <= pend_in;
      out_res_ff  <= out_res_in;
      out_last_ff <= out_last_in;
   end

endmodule

// File: design/midi_to_gate_cv_mapper.sv
// MIDI to gate/CV mapper. Bytes (tuser 0) are gathered into three-byte channel
// messages starting at a status 0x80..0xEF; map writes (tuser 1) load one field
// of a gate record. A complete message walks the eight gate records one per
// cycle while the result side accepts, and sends one transaction per matching
// gate in gate order, tlast on the final one; a message with no match sends
// nothing. The back end loads a message, scans the records and flushes the held
// result, waiting while the result side stalls; a map write is applied as it is
// popped; MIDI bytes not ending a message never reach the back end. A two-entry
// command queue lets the byte parser take transactions during a scan until full.
module midi_to_gate_cv_mapper
   import m2gcv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // req_type
   input  logic [23:0] req_tdata,   // midi_byte, map_gate, map_field, map_value, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // gate_index, gate_write, gate_level, dac_write,
                                    // dac_code, zero pad
   output logic        rsp_tlast
);

   logic    q_full;
   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_not_empty;
   logic    q_pop;
   cmd_type q_pop_cmd;
   res_type res;

   m2gcv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_type  (req_tuser[0]),
      .in_byte  (req_tdata[7:0]),
      .in_gate  (req_tdata[10:8]),
      .in_field (req_tdata[13:11]),
      .in_value (req_tdata[21:14]),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_push_cmd)
   );

   m2gcv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .pop_cmd   (q_pop_cmd)
   );

   m2gcv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd       (q_pop_cmd),
      .cmd_pop   (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (res),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, res.dac_code, res.dac_write, res.gate_level,
                       res.gate_write, res.gate_index};

endmodule
